// ===== rtl/core/frt_pkg.sv =====
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types for the freed region tracker: request commands, table entry
// layout and the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package frt_pkg;

   typedef enum logic [1:0] {
      CMD_REGISTER   = 2'd0,
      CMD_UNREGISTER = 2'd1,
      CMD_DOUBLE     = 2'd2,
      CMD_USE        = 2'd3
   } cmd_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] bytes;
      logic [31:0] start;
   } entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic scan;
      logic finish;
   } ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic done;
   } status_type;

endpackage

// ===== rtl/core/frt_ctrl.sv =====
// ----------------------------------------------------------------------------
// frt_ctrl
// Sequencer for the tracker: accepts one request, runs the table scan when
// the command needs one, and hands the result to the response register.
// ----------------------------------------------------------------------------
module frt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output frt_pkg::ctl_type    ctl,
   input  frt_pkg::status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctl          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               if (frt_pkg::cmd_type'(req_command) == frt_pkg::CMD_REGISTER) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            ctl.scan = 1'b1;
            if (status.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold the result until the response register can take it.
            if (out_free) begin
               ctl.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/frt_datapath.sv =====
// ----------------------------------------------------------------------------
// frt_datapath
// Region table memory kept as a ring (oldest entry at the head), the scan
// pipeline that reads one entry per cycle, the detection counters and the
// response payload register.
// ----------------------------------------------------------------------------
module frt_datapath #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  frt_pkg::ctl_type    ctl,
   output frt_pkg::status_type status,
   input  logic [1:0]          req_command,
   input  logic [31:0]         req_address,
   input  logic [31:0]         req_region_size,
   output logic                rsp_safe,
   output logic [31:0]         rsp_double_free_total,
   output logic [31:0]         rsp_use_after_free_total
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   frt_pkg::entry_type mem [TABLE_DEPTH];

   frt_pkg::cmd_type   cmd_ff;
   logic [31:0]        addr_ff;
   logic [31:0]        size_ff;
   logic               skip_ff;

   logic [AW-1:0]      head_ff, head_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      used_ff, used_in;
   logic [31:0]        df_count_ff, df_count_in;
   logic [31:0]        uaf_count_ff, uaf_count_in;

   logic [CW-1:0]      idx_ff;
   logic [AW-1:0]      rd_ptr_ff;
   logic [AW-1:0]      cmp_ptr_ff;
   logic               pend_ff;
   frt_pkg::entry_type rd_data_ff;
   logic               found_ff;
   logic [AW-1:0]      hit_ptr_ff;

   logic               issue;
   logic               match;
   logic               hit;
   logic               exhausted;
   logic [31:0]        range_end;
   logic               full;
   logic               wr_en;
   logic [AW-1:0]      wr_ptr;
   frt_pkg::entry_type wr_data;
   logic               safe_in;

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
      next_slot = (p == LAST_SLOT) ? '0 : p + AW'(1);
   endfunction

   assign full      = (used_ff == FULL_COUNT);
   assign issue     = ctl.scan && (idx_ff != used_ff);
   assign range_end = rd_data_ff.start + rd_data_ff.bytes;

   always_comb begin
      case (cmd_ff)
         frt_pkg::CMD_UNREGISTER: match = (rd_data_ff.start == addr_ff);
         frt_pkg::CMD_DOUBLE:     match = rd_data_ff.valid && (rd_data_ff.start == addr_ff);
         frt_pkg::CMD_USE:        match = rd_data_ff.valid && (rd_data_ff.start != 32'd0) &&
                                          (addr_ff >= rd_data_ff.start) &&
                                          (addr_ff < range_end);
         default:                 match = 1'b0;
      endcase
   end

   assign hit         = pend_ff && match && !skip_ff;
   assign exhausted   = !pend_ff && (idx_ff == used_ff);
   assign status.done = skip_ff || hit || exhausted;

   // Table writes happen only when the result is handed over, never during a scan.
   always_comb begin
      wr_en   = 1'b0;
      wr_ptr  = tail_ff;
      wr_data = '0;
      head_in = head_ff;
      tail_in = tail_ff;
      used_in = used_ff;
      if (ctl.finish) begin
         if (cmd_ff == frt_pkg::CMD_REGISTER) begin
            wr_en         = 1'b1;
            wr_data.valid = 1'b1;
            wr_data.bytes = size_ff;
            wr_data.start = addr_ff;
            tail_in       = next_slot(tail_ff);
            if (full) begin
               head_in = next_slot(head_ff);
            end else begin
               used_in = used_ff + CW'(1);
            end
         end else if (cmd_ff == frt_pkg::CMD_UNREGISTER && found_ff) begin
            wr_en  = 1'b1;
            wr_ptr = hit_ptr_ff;
         end
      end
   end

   always_comb begin
      df_count_in  = df_count_ff;
      uaf_count_in = uaf_count_ff;
      safe_in      = 1'b1;
      if (cmd_ff == frt_pkg::CMD_DOUBLE || cmd_ff == frt_pkg::CMD_USE) begin
         safe_in = !(skip_ff || found_ff);
      end
      if (ctl.finish && found_ff) begin
         if (cmd_ff == frt_pkg::CMD_DOUBLE) begin
            df_count_in = df_count_ff + 32'd1;
         end
         if (cmd_ff == frt_pkg::CMD_USE) begin
            uaf_count_in = uaf_count_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff     <= frt_pkg::cmd_type'(req_command);
         addr_ff    <= req_address;
         size_ff    <= req_region_size;
         skip_ff    <= (req_address == 32'd0) &&
                       (frt_pkg::cmd_type'(req_command) == frt_pkg::CMD_DOUBLE ||
                        frt_pkg::cmd_type'(req_command) == frt_pkg::CMD_USE);
         idx_ff     <= '0;
         rd_ptr_ff  <= head_ff;
         pend_ff    <= 1'b0;
         found_ff   <= 1'b0;
      end else if (ctl.scan) begin
         pend_ff <= issue;
         if (issue) begin
            idx_ff     <= idx_ff + CW'(1);
            rd_ptr_ff  <= next_slot(rd_ptr_ff);
            cmp_ptr_ff <= rd_ptr_ff;
         end
         if (hit) begin
            found_ff   <= 1'b1;
            hit_ptr_ff <= cmp_ptr_ff;
         end
      end
      if (ctl.finish) begin
         rsp_safe                 <= safe_in;
         rsp_double_free_total    <= df_count_in;
         rsp_use_after_free_total <= uaf_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         used_ff      <= '0;
         df_count_ff  <= '0;
         uaf_count_ff <= '0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         used_ff      <= used_in;
         df_count_ff  <= df_count_in;
         uaf_count_ff <= uaf_count_in;
      end
   end

endmodule

// ===== rtl/core/freed_region_tracker.sv =====
// ----------------------------------------------------------------------------
// freed_region_tracker
// Oldest-first table of freed memory regions with double-free and
// use-after-free checks and running detection counters.
// ----------------------------------------------------------------------------
// Usage:
// A request (req_command, req_address, req_region_size) is taken when
// req_valid is high and req_stall is low. Exactly one response follows on
// rsp_safe and the two counter totals, taken when rsp_valid is high and
// rsp_stall is low. One request is in flight at a time; req_stall stays
// high from acceptance until its response is loaded.
// A register request skips the scan and goes straight to the done state. The
// other commands scan the table one entry per cycle through the single read
// port of the table memory and stop at the first hit, the oldest matching
// slot in use; a miss reads all N slots in use (at most TABLE_DEPTH). Checks
// of address zero and scans of an empty table end the scan without comparing
// an entry. The next request can be taken in the same cycle as the response
// appears.
// Reset empties the table and clears both counters at once; no sweep runs.
// When the receiver stalls, the response is held and the next result
// waits in the controller until the response register frees up.
// ----------------------------------------------------------------------------
module freed_region_tracker #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_address,
   input  logic [31:0] req_region_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_safe,
   output logic [31:0] rsp_double_free_total,
   output logic [31:0] rsp_use_after_free_total
);

   frt_pkg::ctl_type    ctl;
   frt_pkg::status_type status;

   frt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .ctl         (ctl),
      .status      (status)
   );

   frt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .ctl                      (ctl),
      .status                   (status),
      .req_command              (req_command),
      .req_address              (req_address),
      .req_region_size          (req_region_size),
      .rsp_safe                 (rsp_safe),
      .rsp_double_free_total    (rsp_double_free_total),
      .rsp_use_after_free_total (rsp_use_after_free_total)
   );

endmodule

// ===== tb/frt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_checker
// Watches the request and response channels of the freed region tracker,
// keeps its own copy of the region table and both detection counters, and
// compares every response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module frt_checker #(
   parameter int DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_address,
   input  logic [31:0] req_region_size,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_safe,
   input  logic [31:0] rsp_double_free_total,
   input  logic [31:0] rsp_use_after_free_total,
   output int          mismatches,
   output int          awaiting
);

   typedef struct packed {
      logic        safe;
      logic [31:0] double_free;
      logic [31:0] use_after_free;
   } outcome_type;

   logic [31:0] kept_start [DEPTH];
   logic [31:0] kept_bytes [DEPTH];
   logic        kept_valid [DEPTH];
   int          kept_count;
   logic [31:0] double_free_seen;
   logic [31:0] use_after_free_seen;
   outcome_type expected_outcomes [$];
   int          errors = 0;

   // Applies one request to the shadow table and returns the response it
   // should produce.
   function automatic outcome_type track_request(frt_pkg::cmd_type cmd,
                                                 logic [31:0] addr,
                                                 logic [31:0] size);
      outcome_type res;
      logic        hit;
      logic [31:0] range_end;
      int          slot;
      res.safe = 1'b1;
      hit = 1'b0;
      case (cmd)
         frt_pkg::CMD_REGISTER: begin
            if (kept_count < DEPTH) begin
               slot = kept_count;
               kept_count++;
            end else begin
               // Full table: the oldest entry falls out of slot zero.
               for (int k = 0; k < DEPTH - 1; k++) begin
                  kept_start[k] = kept_start[k + 1];
                  kept_bytes[k] = kept_bytes[k + 1];
                  kept_valid[k] = kept_valid[k + 1];
               end
               slot = DEPTH - 1;
            end
            kept_start[slot] = addr;
            kept_bytes[slot] = size;
            kept_valid[slot] = 1'b1;
         end
         frt_pkg::CMD_UNREGISTER: begin
            // The first matching slot is cleared even when it is already a hole.
            for (int k = 0; k < kept_count; k++) begin
               if (!hit && kept_start[k] == addr) begin
                  hit = 1'b1;
                  kept_start[k] = '0;
                  kept_bytes[k] = '0;
                  kept_valid[k] = 1'b0;
               end
            end
         end
         frt_pkg::CMD_DOUBLE: begin
            if (addr == '0) begin
               res.safe = 1'b0;
            end else begin
               for (int k = 0; k < kept_count; k++) begin
                  if (kept_valid[k] && kept_start[k] == addr) hit = 1'b1;
               end
               if (hit) begin
                  res.safe = 1'b0;
                  double_free_seen++;
               end
            end
         end
         default: begin
            if (addr == '0) begin
               res.safe = 1'b0;
            end else begin
               // The end of a region wraps at 32 bits, which leaves it empty.
               for (int k = 0; k < kept_count; k++) begin
                  range_end = kept_start[k] + kept_bytes[k];
                  if (kept_valid[k] && kept_start[k] != '0 &&
                      addr >= kept_start[k] && addr < range_end) hit = 1'b1;
               end
               if (hit) begin
                  res.safe = 1'b0;
                  use_after_free_seen++;
               end
            end
         end
      endcase
      res.double_free = double_free_seen;
      res.use_after_free = use_after_free_seen;
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            kept_start[k] = '0;
            kept_bytes[k] = '0;
            kept_valid[k] = 1'b0;
         end
         kept_count = 0;
         double_free_seen = '0;
         use_after_free_seen = '0;
         expected_outcomes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t: response with nothing expected, expected none, actual %0b %0h %0h",
                        $time, rsp_safe, rsp_double_free_total, rsp_use_after_free_total);
               errors++;
            end else begin
               want = expected_outcomes.pop_front();
               compare_field("safe", {31'b0, want.safe}, {31'b0, rsp_safe});
               compare_field("double_free_total", want.double_free, rsp_double_free_total);
               compare_field("use_after_free_total", want.use_after_free,
                             rsp_use_after_free_total);
            end
         end
         if (req_valid && !req_stall) begin
            expected_outcomes.push_back(track_request(frt_pkg::cmd_type'(req_command),
                                                      req_address, req_region_size));
         end
      end
      awaiting <= expected_outcomes.size();
      mismatches <= errors;
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random region commands into the freed region tracker
// under varying sender and receiver idling, with a long receiver hold-off,
// and reports the verdict from the checker's mismatch and awaiting counts.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DEPTH          = 256;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_AT        = 300;
   localparam int HOLD_CYCLES    = 400;
   localparam int POOL_LIMIT     = 320;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = frt_pkg::CMD_REGISTER;
   logic [31:0] req_address = '0;
   logic [31:0] req_region_size = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_safe;
   logic [31:0] rsp_double_free_total;
   logic [31:0] rsp_use_after_free_total;

   int          mismatches;
   int          awaiting;
   int          send_idle_pct = 0;
   int          rsp_idle_pct = 0;
   int          requests_taken = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          quiet_cycles = 0;
   logic [31:0] pool_start [$];
   logic [31:0] freed_bytes [$];

   wire req_taken = req_valid && !req_stall;
   wire rsp_taken = rsp_valid && !rsp_stall;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   freed_region_tracker #(.TABLE_DEPTH(DEPTH)) dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_command             (req_command),
      .req_address             (req_address),
      .req_region_size         (req_region_size),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_safe                (rsp_safe),
      .rsp_double_free_total   (rsp_double_free_total),
      .rsp_use_after_free_total(rsp_use_after_free_total)
   );

   frt_checker #(.DEPTH(DEPTH)) u_checker (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_command             (req_command),
      .req_address             (req_address),
      .req_region_size         (req_region_size),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_safe                (rsp_safe),
      .rsp_double_free_total   (rsp_double_free_total),
      .rsp_use_after_free_total(rsp_use_after_free_total),
      .mismatches              (mismatches),
      .awaiting                (awaiting)
   );

   // Receiver: random stalls, plus one long hold-off that backs the block up
   // while the sender keeps offering requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && requests_taken >= HOLD_AT) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (req_taken) requests_taken <= requests_taken + 1;
      if (reset || req_taken || rsp_taken) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("** freed_region_tracker: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input frt_pkg::cmd_type cmd, input logic [31:0] addr,
                               input logic [31:0] size);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_address <= addr;
      req_region_size <= size;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // The sender stays quiet until every predicted response has been taken.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
   endtask

   // Most checks and unregisters aim at regions that were registered
   // recently, so hits, holes and edge addresses come up often.
   task automatic send_random();
      int               pick;
      int               idx;
      frt_pkg::cmd_type cmd;
      logic [31:0]      addr;
      logic [31:0]      size;
      logic [31:0]      base;
      logic [31:0]      span;
      pick = $urandom_range(0, 99);
      if (pick < 30) cmd = frt_pkg::CMD_REGISTER;
      else if (pick < 45) cmd = frt_pkg::CMD_UNREGISTER;
      else if (pick < 70) cmd = frt_pkg::CMD_DOUBLE;
      else cmd = frt_pkg::CMD_USE;
      addr = $urandom;
      size = $urandom;
      pick = $urandom_range(0, 99);
      if (cmd == frt_pkg::CMD_REGISTER) begin
         if (pick < 5) addr = '0;
         else if (pick < 15) addr = {16'hFFFF, addr[15:0]};
         else if (pick < 25 && pool_start.size() != 0)
            addr = pool_start[$urandom_range(0, pool_start.size() - 1)];
         pick = $urandom_range(0, 99);
         if (pick < 10) size = '0;
         else if (pick < 15) size = '1;
         else if (pick >= 30) size = $urandom_range(1, 4096);
         pool_start.push_back(addr);
         freed_bytes.push_back(size);
         if (pool_start.size() > POOL_LIMIT) begin
            void'(pool_start.pop_front());
            void'(freed_bytes.pop_front());
         end
      end else if (pick < 5) begin
         addr = '0;
      end else if (pick < 75 && pool_start.size() != 0) begin
         idx = $urandom_range(0, pool_start.size() - 1);
         base = pool_start[idx];
         span = freed_bytes[idx];
         addr = base;
         if (cmd == frt_pkg::CMD_USE) begin
            case ($urandom_range(0, 4))
               0: addr = base;
               1: addr = base + span - 1;
               2: addr = base + span;
               3: addr = base - 1;
               default: addr = base + $urandom_range(0, span);
            endcase
         end
      end
      send_request(cmd, addr, size);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 8;
      rsp_idle_pct <= 73;

      // Zero addresses on an empty table.
      send_request(frt_pkg::CMD_DOUBLE, 32'h0, 32'h0);
      send_request(frt_pkg::CMD_USE, 32'h0, 32'hFFFF_FFFF);
      send_request(frt_pkg::CMD_UNREGISTER, 32'h0, 32'h0);
      // A plain region and the addresses around its edges.
      send_request(frt_pkg::CMD_REGISTER, 32'h0000_1000, 32'h100);
      send_request(frt_pkg::CMD_DOUBLE, 32'h0000_1000, 32'h0);
      send_request(frt_pkg::CMD_USE, 32'h0000_1000, 32'h0);
      send_request(frt_pkg::CMD_USE, 32'h0000_10FF, 32'h0);
      send_request(frt_pkg::CMD_USE, 32'h0000_1100, 32'h0);
      send_request(frt_pkg::CMD_USE, 32'h0000_0FFF, 32'h0);
      // Regions whose end wraps, or that have no size, cover nothing.
      send_request(frt_pkg::CMD_REGISTER, 32'hFFFF_FFF0, 32'h20);
      send_request(frt_pkg::CMD_USE, 32'hFFFF_FFF8, 32'h0);
      send_request(frt_pkg::CMD_REGISTER, 32'h0000_2000, 32'h0);
      send_request(frt_pkg::CMD_USE, 32'h0000_2000, 32'h0);
      send_request(frt_pkg::CMD_DOUBLE, 32'h0000_2000, 32'h0);
      // A region at address zero is skipped by the use check.
      send_request(frt_pkg::CMD_REGISTER, 32'h0, 32'hFFFF_FFFF);
      send_request(frt_pkg::CMD_USE, 32'h0000_0005, 32'h0);
      send_request(frt_pkg::CMD_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(frt_pkg::CMD_DOUBLE, 32'hFFFF_FFFF, 32'h0);
      // Unregister leaves a hole, and unregistering zero clears a hole again.
      send_request(frt_pkg::CMD_UNREGISTER, 32'h0000_1000, 32'h0);
      send_request(frt_pkg::CMD_DOUBLE, 32'h0000_1000, 32'h0);
      send_request(frt_pkg::CMD_USE, 32'h0000_1050, 32'h0);
      send_request(frt_pkg::CMD_UNREGISTER, 32'h0, 32'h0);
      send_request(frt_pkg::CMD_UNREGISTER, 32'h1234_5678, 32'h0);
      // With duplicate starts only the first is removed.
      send_request(frt_pkg::CMD_REGISTER, 32'h0000_3000, 32'h10);
      send_request(frt_pkg::CMD_REGISTER, 32'h0000_3000, 32'h100);
      send_request(frt_pkg::CMD_UNREGISTER, 32'h0000_3000, 32'h0);
      send_request(frt_pkg::CMD_DOUBLE, 32'h0000_3000, 32'h0);

      repeat (640) send_random();
      drain_responses();

      send_idle_pct = 73;
      rsp_idle_pct <= 8;
      repeat (650) send_random();
      drain_responses();

      send_idle_pct = 0;
      rsp_idle_pct <= 0;
      repeat (660) send_random();
      drain_responses();

      repeat (DEPTH + 10) @(posedge clock);
      if (mismatches == 0 && awaiting == 0) begin
         $display("** freed_region_tracker: PASSED **");
      end else begin
         if (awaiting != 0) $display("%0t: %0d responses never arrived", $time, awaiting);
         $display("** freed_region_tracker: FAILED **");
      end
      $finish;
   end

endmodule
